/* rtl/assert_macros.svh */
// Assertion helpers for the RTL. Simulation builds get real concurrent
// assertions; synthesis builds see empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The property must hold at every rising clock edge outside reset.
`define LPM_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("lpm assertion failed");

// The expression must never be true at a rising clock edge outside reset.
`define LPM_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("lpm forbidden condition seen");

`else

`define LPM_ASSERT(label, clk, rst_n, prop)

`define LPM_NEVER(label, clk, rst_n, expr)

`endif

`endif

/* rtl/lpm_pkg.sv */
package lpm_pkg;

    localparam int ADDR_W  = 32;
    localparam int LEN_W   = 6;
    localparam int PORT_W  = 4;
    localparam int TTL_W   = 8;
    localparam int STAT_W  = 3;
    localparam int MAX_LEN = 32;
    localparam int PORT_N  = 2 ** PORT_W;

    // Operation codes of an input beat.
    localparam logic OP_ADD    = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    // Result status codes.
    localparam logic [STAT_W-1:0] ST_FORWARDED   = 3'd0;
    localparam logic [STAT_W-1:0] ST_TTL_EXPIRED = 3'd1;
    localparam logic [STAT_W-1:0] ST_NO_ROUTE    = 3'd2;
    localparam logic [STAT_W-1:0] ST_ADDED       = 3'd3;
    localparam logic [STAT_W-1:0] ST_FULL        = 3'd4;

    typedef struct packed {
        logic              op;
        logic [ADDR_W-1:0] address;
        logic [LEN_W-1:0]  prefix_len;
        logic [ADDR_W-1:0] gateway;
        logic              has_gateway;
        logic [PORT_W-1:0] port_index;
        logic [TTL_W-1:0]  ttl_in;
    } t_in_beat;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [PORT_W-1:0] out_port;
        logic [ADDR_W-1:0] hop_address;
        logic [TTL_W-1:0]  ttl_out;
    } t_out_beat;

    // One route table entry as held in memory.
    typedef struct packed {
        logic [ADDR_W-1:0] prefix;
        logic [LEN_W-1:0]  length;
        logic [ADDR_W-1:0] gateway;
        logic              direct;
        logic [PORT_W-1:0] port;
    } t_entry;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_DONE
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic scan;
        logic commit;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic quick;
        logic empty;
        logic last;
        logic out_free;
    } t_sts;

    // Network mask for a prefix length; lengths of 32 and above give all ones.
    function automatic logic [ADDR_W-1:0] len_mask(input logic [LEN_W-1:0] len);
        logic [ADDR_W-1:0] mask;
        if (len == '0) begin
            mask = '0;
        end else if (len >= LEN_W'(MAX_LEN)) begin
            mask = '1;
        end else begin
            mask = {ADDR_W{1'b1}} << (LEN_W'(MAX_LEN) - len);
        end
        return mask;
    endfunction

endpackage

/* rtl/lpm_ram.sv */
module lpm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/lpm_ctrl.sv */
module lpm_ctrl import lpm_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_in_stall
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = (i_sts.quick || i_sts.empty) ? S_DONE : S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_sts.last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.load = i_in_valid;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
            end
            S_DRAIN: begin
                o_cmd = '0;
            end
            S_DONE: begin
                o_cmd.commit = i_sts.out_free;
            end
        endcase
    end

endmodule

/* rtl/lpm_dp.sv */
module lpm_dp import lpm_pkg::*; #(
    parameter int ROUTES = 64,
    parameter int PORTS  = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_beat  i_in,
    input  logic      i_out_stall,
    input  t_cmd      i_cmd,
    output t_sts      o_sts,
    output t_out_beat o_out,
    output logic      o_out_valid
);

    localparam int IW = (ROUTES > 1) ? $clog2(ROUTES) : 1;
    localparam int CW = $clog2(ROUTES + 1);
    localparam int EW = $bits(t_entry);

    // Interface index reduced modulo the interface count, one entry per code.
    logic [PORT_W-1:0] port_mod [PORT_N];

    for (genvar g = 0; g < PORT_N; g++) begin : g_port_mod
        assign port_mod[g] = PORT_W'(g % PORTS);
    end

    // Item held for the whole scan.
    logic              r_op;
    logic [ADDR_W-1:0] r_addr;
    logic [LEN_W-1:0]  r_len;
    logic [ADDR_W-1:0] r_gw;
    logic              r_direct;
    logic [PORT_W-1:0] r_port;
    logic [TTL_W-1:0]  r_ttl;

    // Scan position, fill count and compare stage.
    logic [IW-1:0]     r_idx;
    logic [CW-1:0]     r_count;
    logic              r_eval;
    logic [IW-1:0]     r_eval_idx;

    // Best entry so far (lookup) or exact hit (add).
    logic              r_found;
    logic [LEN_W-1:0]  r_best_len;
    logic [PORT_W-1:0] r_best_port;
    logic [ADDR_W-1:0] r_best_gw;
    logic              r_best_direct;
    logic [IW-1:0]     r_hit_idx;

    t_out_beat         r_out;
    logic              r_out_valid;
    t_out_beat         n_out;

    logic [EW-1:0]     ram_rdata;
    t_entry            rd_entry;
    t_entry            wr_entry;
    logic              ram_we;
    logic [IW-1:0]     ram_waddr;
    logic [ADDR_W-1:0] mask;
    logic              add_hit;
    logic              lkp_hit;
    logic              take;
    logic              full;

    lpm_ram #(
        .WIDTH (EW),
        .DEPTH (ROUTES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (wr_entry),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    assign rd_entry = t_entry'(ram_rdata);
    assign mask     = len_mask(rd_entry.length);
    assign full     = (r_count == CW'(ROUTES));

    always_comb begin
        add_hit = (rd_entry.prefix == r_addr) && (rd_entry.length == r_len) && !r_found;
        lkp_hit = (rd_entry.length <= LEN_W'(MAX_LEN))
               && ((r_addr & mask) == rd_entry.prefix)
               && (!r_found || (rd_entry.length > r_best_len));
        take    = r_eval && ((r_op == OP_ADD) ? add_hit : lkp_hit);
    end

    always_comb begin
        wr_entry.prefix  = r_addr;
        wr_entry.length  = r_len;
        wr_entry.gateway = r_gw;
        wr_entry.direct  = r_direct;
        wr_entry.port    = r_port;
        ram_we    = i_cmd.commit && (r_op == OP_ADD) && (r_found || !full);
        ram_waddr = r_found ? r_hit_idx : r_count[IW-1:0];
    end

    always_comb begin
        n_out = '0;
        if (r_op == OP_ADD) begin
            n_out.status = (r_found || !full) ? ST_ADDED : ST_FULL;
        end else if (r_ttl <= TTL_W'(1)) begin
            n_out.status = ST_TTL_EXPIRED;
        end else if (r_found) begin
            n_out.status      = ST_FORWARDED;
            n_out.out_port    = r_best_port;
            n_out.hop_address = r_best_direct ? r_addr : r_best_gw;
            n_out.ttl_out     = r_ttl - TTL_W'(1);
        end else begin
            n_out.status = ST_NO_ROUTE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op     <= i_in.op;
            r_addr   <= i_in.address;
            r_len    <= i_in.prefix_len;
            r_gw     <= i_in.has_gateway ? i_in.gateway : '0;
            r_direct <= !i_in.has_gateway;
            r_port   <= port_mod[i_in.port_index];
            r_ttl    <= i_in.ttl_in;
        end
        if (i_cmd.scan) begin
            r_eval_idx <= r_idx;
        end
        if (take) begin
            r_best_len    <= rd_entry.length;
            r_best_port   <= rd_entry.port;
            r_best_gw     <= rd_entry.gateway;
            r_best_direct <= rd_entry.direct;
            r_hit_idx     <= r_eval_idx;
        end
        if (i_cmd.commit) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_count     <= '0;
            r_eval      <= 1'b0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_eval <= i_cmd.scan;
            if (i_cmd.load) begin
                r_idx   <= '0;
                r_found <= 1'b0;
            end else begin
                if (i_cmd.scan) begin
                    r_idx <= r_idx + IW'(1);
                end
                if (take) begin
                    r_found <= 1'b1;
                end
            end
            if (i_cmd.commit && (r_op == OP_ADD) && !r_found && !full) begin
                r_count <= r_count + CW'(1);
            end
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_sts.quick    = (i_in.op == OP_LOOKUP) && (i_in.ttl_in <= TTL_W'(1));
        o_sts.empty    = (r_count == '0);
        o_sts.last     = ((CW'(r_idx) + CW'(1)) == r_count);
        o_sts.out_free = !r_out_valid || !i_out_stall;
    end

    assign o_out       = r_out;
    assign o_out_valid = r_out_valid;

endmodule

/* rtl/longest_prefix_match_router_top.sv */
// A beat is compared against each of the N stored routes in turn before its
// result is registered; an expired TTL or an empty table skips the scan.
// The scan reads one table entry per cycle through the single read port, and
// the input stays stalled until a beat's result is committed, so no new beat
// is taken while one is still being scanned.
// Reset (synchronous, active low) empties the table at once; there is no clearing pass.
`include "assert_macros.svh"

module longest_prefix_match_router_top import lpm_pkg::*; #(
    parameter int ROUTES = 64,
    parameter int PORTS  = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_beat  i_in,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    output t_out_beat o_out,
    output logic      o_out_valid,
    input  logic      i_out_stall
);

    // The controller sequences each beat: it takes the beat, walks the
    // table one entry per cycle unless the TTL has expired or the table is
    // empty, waits in the drain state for the last compare, and then commits
    // the result. Commands and status are the only link between the controller and the datapath.
    t_cmd w_cmd;
    t_sts w_sts;

    lpm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd),
        .o_in_stall (o_in_stall)
    );

    // The datapath owns the route memory and its fill count. Routes are
    // never removed, so valid entries always occupy the lowest indexes and
    // the fill count stands in for per-entry valid bits. An add that finds
    // no exact match appends at the fill count; a lookup keeps the first
    // entry with the longest matching length. The result sits in an output
    // register, so a new beat can be taken while a result is still stalled.
    lpm_dp #(
        .ROUTES (ROUTES),
        .PORTS  (PORTS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_out_stall (i_out_stall),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_out       (o_out),
        .o_out_valid (o_out_valid)
    );

    // A commit always presents a result beat in the next cycle.
    `LPM_ASSERT(a_commit_shows_beat, i_clk, i_rst_n, w_cmd.commit |=> o_out_valid)

    // A result beat that is still stalled is never overwritten by a commit.
    `LPM_NEVER(a_no_commit_over_stall, i_clk, i_rst_n, w_cmd.commit && o_out_valid && i_out_stall)

    // Once a beat is taken, the input side stalls until its result is committed.
    `LPM_ASSERT(a_accept_then_stall, i_clk, i_rst_n, (i_in_valid && !o_in_stall) |=> o_in_stall)

    // Table reads never overlap taking a beat or committing a result.
    `LPM_NEVER(a_scan_exclusive, i_clk, i_rst_n, w_cmd.scan && (w_cmd.load || w_cmd.commit))

endmodule
